/* rtl/dotq_pkg.sv */
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types, constants and the helper function of the deadline-ordered
// transmit queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int DEDUP_SLOTS = 100;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int RES_W = (DEDUP_SLOTS > 1) ? $clog2(DEDUP_SLOTS) : 1;

	// Residue by reciprocal multiplication: the rounded-up reciprocal keeps the
	// quotient exact for every 12-bit sequence number.
	localparam int RECIP_SH = 24;
	localparam int RECIP_W = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + DEDUP_SLOTS - 1) / DEDUP_SLOTS);
	localparam int QUO_W = 12;

	localparam logic [21:0] MAX_BYTES_RST = 22'(2 * 1024 * 1024);

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCARD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEDUP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RNTI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LCID = 3'd4;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_GRANT = 2'd1,
		REQ_TICK = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		KIND_STATUS = 3'd0,
		KIND_SENT = 3'd1,
		KIND_DEADLINE = 3'd2,
		KIND_DUP = 3'd3,
		KIND_REJECT = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ENQ_CHECK,
		ST_ENQ_SCAN,
		ST_ENQ_INSERT,
		ST_REJECT,
		ST_REPORT,
		ST_DL_SCAN,
		ST_DUP_START,
		ST_DUP_CALC,
		ST_DUP_CHECK,
		ST_STATUS,
		ST_GRANT
	} state_t;

	typedef struct packed {
		logic  req_load;
		logic  idx_clr;
		logic  idx_inc;
		logic  pos_clr;
		logic  pos_inc;
		logic  pos_load_cnt;
		logic  insert;
		logic  remove;
		logic  quo_load;
		logic  seen_clr;
		logic  seen_set;
		logic  emit;
		kind_t kind;
		logic  last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       count_zero;
		logic       reject;
		logic       discard_nz;
		logic       dedup_en;
		logic       idx_lt_cnt;
		logic       time_le_ts;
		logic       age_over;
		logic       seen_hit;
		logic       grant_fits;
		logic       out_free;
	} stat_t;

	function automatic logic [31:0] age_of(input logic [31:0] now, input logic [31:0] ts);
		age_of = (now >= ts) ? (now - ts) : 32'd0;
	endfunction

endpackage

/* rtl/dotq_ctrl.sv */
// ----------------------------------------------------------------------------
// dotq_ctrl
// Sequencer that walks one request through insertion or grant, purge,
// duplicate scan and result emission.
// ----------------------------------------------------------------------------
module dotq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             idle,
	input  dotq_pkg::stat_t  st,
	output dotq_pkg::cmd_t   cmd
);

	dotq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dotq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.kind = dotq_pkg::KIND_STATUS;
		idle = 1'b0;
		case (state_q)
			dotq_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (s_tvalid) begin
					cmd.req_load = 1'b1;
					state_d = dotq_pkg::ST_DISPATCH;
				end
			end
			dotq_pkg::ST_DISPATCH: begin
				cmd.idx_clr = 1'b1;
				case (st.req_type)
					dotq_pkg::REQ_ENQUEUE: state_d = dotq_pkg::ST_ENQ_CHECK;
					dotq_pkg::REQ_GRANT: state_d = dotq_pkg::ST_GRANT;
					dotq_pkg::REQ_TICK:
						state_d = st.count_zero ? dotq_pkg::ST_IDLE : dotq_pkg::ST_REPORT;
					default: state_d = dotq_pkg::ST_IDLE;
				endcase
			end
			dotq_pkg::ST_ENQ_CHECK: begin
				if (st.reject) begin
					state_d = dotq_pkg::ST_REJECT;
				end else if (st.discard_nz) begin
					cmd.pos_clr = 1'b1;
					state_d = dotq_pkg::ST_ENQ_SCAN;
				end else begin
					cmd.pos_load_cnt = 1'b1;
					state_d = dotq_pkg::ST_ENQ_INSERT;
				end
			end
			dotq_pkg::ST_ENQ_SCAN: begin
				if (st.idx_lt_cnt) begin
					cmd.idx_inc = 1'b1;
					cmd.pos_inc = st.time_le_ts;
				end else begin
					state_d = dotq_pkg::ST_ENQ_INSERT;
				end
			end
			dotq_pkg::ST_ENQ_INSERT: begin
				cmd.insert = 1'b1;
				state_d = dotq_pkg::ST_REPORT;
			end
			dotq_pkg::ST_REJECT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = dotq_pkg::KIND_REJECT;
					state_d = dotq_pkg::ST_REPORT;
				end
			end
			dotq_pkg::ST_REPORT: begin
				cmd.seen_clr = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d = st.discard_nz ? dotq_pkg::ST_DL_SCAN : dotq_pkg::ST_DUP_START;
			end
			dotq_pkg::ST_DL_SCAN: begin
				if (!st.idx_lt_cnt) begin
					state_d = dotq_pkg::ST_DUP_START;
				end else if (!st.age_over) begin
					cmd.idx_inc = 1'b1;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = dotq_pkg::KIND_DEADLINE;
					cmd.remove = 1'b1;
				end
			end
			dotq_pkg::ST_DUP_START: begin
				cmd.idx_clr = 1'b1;
				state_d = st.dedup_en ? dotq_pkg::ST_DUP_CALC : dotq_pkg::ST_STATUS;
			end
			dotq_pkg::ST_DUP_CALC: begin
				if (st.idx_lt_cnt) begin
					cmd.quo_load = 1'b1;
					state_d = dotq_pkg::ST_DUP_CHECK;
				end else begin
					state_d = dotq_pkg::ST_STATUS;
				end
			end
			dotq_pkg::ST_DUP_CHECK: begin
				if (!st.seen_hit) begin
					cmd.seen_set = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d = dotq_pkg::ST_DUP_CALC;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = dotq_pkg::KIND_DUP;
					cmd.remove = 1'b1;
					state_d = dotq_pkg::ST_DUP_CALC;
				end
			end
			dotq_pkg::ST_STATUS: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = dotq_pkg::KIND_STATUS;
					cmd.last = 1'b1;
					state_d = dotq_pkg::ST_IDLE;
				end
			end
			dotq_pkg::ST_GRANT: begin
				if (st.count_zero || !st.grant_fits) begin
					state_d = dotq_pkg::ST_IDLE;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = dotq_pkg::KIND_SENT;
					cmd.last = 1'b1;
					cmd.remove = 1'b1;
					state_d = dotq_pkg::ST_IDLE;
				end
			end
			default: state_d = dotq_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/dotq_dp.sv */
// ----------------------------------------------------------------------------
// dotq_dp
// Datapath: request and configuration registers, the entry store with its
// shift network, scan counters, residue marks and the result register.
// ----------------------------------------------------------------------------
module dotq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dotq_pkg::cmd_t                   cmd,
	output dotq_pkg::stat_t                  st,
	input  logic [1:0]                       s_tuser,
	input  logic [135:0]                     s_tdata,
	input  logic                             cfg_valid,
	input  logic [dotq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [127:0]                     m_tdata,
	output logic [2:0]                       m_tuser,
	output logic                             m_tlast
);

	localparam int DEPTH = dotq_pkg::QUEUE_DEPTH;
	localparam int CNT_W = dotq_pkg::CNT_W;
	localparam int IDX_W = dotq_pkg::IDX_W;
	localparam int RES_W = dotq_pkg::RES_W;
	localparam int QUO_W = dotq_pkg::QUO_W;
	localparam int PROD_W = 12 + dotq_pkg::RECIP_W;
	localparam int DEDUP_W_MSB = dotq_pkg::DEDUP_SLOTS - 1;

	// Configuration.
	logic [21:0] max_bytes_q;
	logic [31:0] discard_q;
	logic        dedup_q;
	logic [15:0] rnti_q;
	logic [4:0]  lcid_q;

	// Captured request.
	logic [1:0]  req_type_q;
	logic [31:0] now_q;
	logic [15:0] handle_q;
	logic [15:0] bytes_q;
	logic [31:0] ts_q;
	logic [11:0] seq_q;
	logic [15:0] grant_q;
	logic [1:0]  layer_q;
	logic [3:0]  harq_q;
	logic [2:0]  carrier_q;

	// Entry store, kept in queue order.
	logic [15:0] ent_handle_q [DEPTH];
	logic [15:0] ent_bytes_q [DEPTH];
	logic [31:0] ent_time_q [DEPTH];
	logic [11:0] ent_seq_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [21:0] buffered_q;

	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEDUP_W_MSB:0] seen_q;

	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic        out_last_q;
	logic [127:0] out_data_q;
	logic [127:0] out_data_d;

	logic [IDX_W-1:0] idx_a;
	logic [15:0] cur_handle;
	logic [15:0] cur_bytes;
	logic [31:0] cur_time;
	logic [11:0] cur_seq;
	logic [22:0] sum_bytes;
	logic [PROD_W-1:0] prod;
	logic [RES_W-1:0] residue;
	logic [11:0] rem_full;
	logic [31:0] hol;

	assign idx_a = idx_q[IDX_W-1:0];
	assign cur_handle = ent_handle_q[idx_a];
	assign cur_bytes = ent_bytes_q[idx_a];
	assign cur_time = ent_time_q[idx_a];
	assign cur_seq = ent_seq_q[idx_a];
	assign sum_bytes = {1'b0, buffered_q} + {7'd0, bytes_q};
	assign prod = PROD_W'(cur_seq) * PROD_W'(dotq_pkg::RECIP);
	assign rem_full = cur_seq - 12'(quo_q * 12'(dotq_pkg::DEDUP_SLOTS));
	assign residue = rem_full[RES_W-1:0];
	assign hol = (count_q == '0) ? 32'd0 : dotq_pkg::age_of(now_q, ent_time_q[0]);

	always_comb begin
		st.req_type = req_type_q;
		st.count_zero = (count_q == '0);
		st.reject = (sum_bytes > {1'b0, max_bytes_q}) || (count_q >= CNT_W'(DEPTH));
		st.discard_nz = (discard_q != '0);
		st.dedup_en = dedup_q;
		st.idx_lt_cnt = (idx_q < count_q);
		st.time_le_ts = (cur_time <= ts_q);
		st.age_over = (dotq_pkg::age_of(now_q, cur_time) > discard_q);
		st.seen_hit = seen_q[residue];
		st.grant_fits = (grant_q >= ent_bytes_q[0]);
		st.out_free = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= dotq_pkg::MAX_BYTES_RST;
			discard_q <= '0;
			dedup_q <= 1'b0;
			rnti_q <= '0;
			lcid_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dotq_pkg::CFG_MAX_BYTES: max_bytes_q <= cfg_data[21:0];
				dotq_pkg::CFG_DISCARD: discard_q <= cfg_data;
				dotq_pkg::CFG_DEDUP: dedup_q <= cfg_data[0];
				dotq_pkg::CFG_RNTI: rnti_q <= cfg_data[15:0];
				dotq_pkg::CFG_LCID: lcid_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_type_q <= s_tuser;
			now_q <= s_tdata[31:0];
			handle_q <= s_tdata[47:32];
			bytes_q <= s_tdata[63:48];
			ts_q <= s_tdata[95:64];
			seq_q <= s_tdata[107:96];
			grant_q <= s_tdata[123:108];
			layer_q <= s_tdata[125:124];
			harq_q <= s_tdata[129:126];
			carrier_q <= s_tdata[132:130];
		end
		if (cmd.quo_load) begin
			quo_q <= prod[dotq_pkg::RECIP_SH +: QUO_W];
		end
		if (cmd.pos_clr) begin
			pos_q <= '0;
		end else if (cmd.pos_load_cnt) begin
			pos_q <= count_q;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + 1'b1;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Shift network: insertion moves entries up from the slot, removal moves
	// entries down over the removed slot.
	always_ff @(posedge clk) begin
		for (int k = 0; k < DEPTH; k++) begin
			if (cmd.insert) begin
				if (CNT_W'(k) == pos_q) begin
					ent_handle_q[k] <= handle_q;
					ent_bytes_q[k] <= bytes_q;
					ent_time_q[k] <= ts_q;
					ent_seq_q[k] <= seq_q;
				end else if (k > 0 && CNT_W'(k) > pos_q) begin
					ent_handle_q[k] <= ent_handle_q[(k > 0) ? k - 1 : 0];
					ent_bytes_q[k] <= ent_bytes_q[(k > 0) ? k - 1 : 0];
					ent_time_q[k] <= ent_time_q[(k > 0) ? k - 1 : 0];
					ent_seq_q[k] <= ent_seq_q[(k > 0) ? k - 1 : 0];
				end
			end else if (cmd.remove) begin
				if (k < DEPTH - 1 && CNT_W'(k) >= idx_q) begin
					ent_handle_q[k] <= ent_handle_q[(k < DEPTH - 1) ? k + 1 : k];
					ent_bytes_q[k] <= ent_bytes_q[(k < DEPTH - 1) ? k + 1 : k];
					ent_time_q[k] <= ent_time_q[(k < DEPTH - 1) ? k + 1 : k];
					ent_seq_q[k] <= ent_seq_q[(k < DEPTH - 1) ? k + 1 : k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			buffered_q <= '0;
			seen_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + 1'b1;
				buffered_q <= sum_bytes[21:0];
			end else if (cmd.remove) begin
				count_q <= count_q - 1'b1;
				buffered_q <= buffered_q - {6'd0, cur_bytes};
			end
			if (cmd.seen_clr) begin
				seen_q <= '0;
			end else if (cmd.seen_set) begin
				seen_q[residue] <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word for the kind being emitted.
	always_comb begin
		out_data_d = '0;
		out_data_d[122:107] = rnti_q;
		out_data_d[127:123] = lcid_q;
		case (cmd.kind)
			dotq_pkg::KIND_REJECT: begin
				out_data_d[15:0] = handle_q;
				out_data_d[31:16] = bytes_q;
				out_data_d[43:32] = seq_q;
			end
			dotq_pkg::KIND_SENT: begin
				out_data_d[15:0] = cur_handle;
				out_data_d[31:16] = cur_bytes;
				out_data_d[43:32] = cur_seq;
				out_data_d[45:44] = layer_q;
				out_data_d[49:46] = harq_q;
				out_data_d[52:50] = carrier_q;
			end
			dotq_pkg::KIND_DEADLINE, dotq_pkg::KIND_DUP: begin
				out_data_d[15:0] = cur_handle;
				out_data_d[31:16] = cur_bytes;
				out_data_d[43:32] = cur_seq;
			end
			dotq_pkg::KIND_STATUS: begin
				out_data_d[74:53] = (count_q == '0) ? 22'd0 : buffered_q;
				out_data_d[106:75] = hol;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			out_last_q <= cmd.last;
			out_data_q <= out_data_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

endmodule

/* rtl/deadline_ordered_tx_queue.sv */
// ----------------------------------------------------------------------------
// deadline_ordered_tx_queue
// Transmit queue with deadline ordering, deadline discard and duplicate
// discard, built as a sequencer and a datapath.
// ----------------------------------------------------------------------------
// The block takes one request at a time: an enqueue, a transmit grant or a
// report tick, selected by s_tuser. An enqueue or a tick walks the stored
// entries, so its cost grows with the queue fill n (up to 32): the search
// for the insert slot, the deadline purge and the duplicate scan each step
// through the entries in order, and each result waits while the output
// register is still held by the sink. Results leave through a single output
// register; m_tlast marks the final result of each request. Configuration
// writes are always accepted and should only be issued while no request is
// in progress.
module deadline_ordered_tx_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, lowest bit up: now_ms[32], pdu_handle[16], pdu_bytes[16],
	// timestamp_ms[32], seq_num[12], grant_bytes[16], layer[2], harq_id[4],
	// carrier_id[3], zero fill[3].
	input  logic [135:0]                    s_tdata,
	// s_tuser: req_type[2].
	input  logic [1:0]                      s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, lowest bit up: pdu_handle_res[16], pdu_bytes_res[16],
	// seq_num_res[12], layer_res[2], harq_id_res[4], carrier_id_res[3],
	// queue_bytes[22], hol_delay_ms[32], rnti_res[16], lcid_res[5].
	output logic [127:0]                    m_tdata,
	// m_tuser: kind[3].
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dotq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	dotq_pkg::cmd_t  cmd;
	dotq_pkg::stat_t st;

	// Registers can be written in any cycle.
	assign cfg_ready = 1'b1;

	dotq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.idle     (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	dotq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* tb/sv/deadline_ordered_tx_queue_chk.sv */
// ----------------------------------------------------------------------------
// deadline_ordered_tx_queue_chk
// Watches the request, result and configuration channels, keeps its own copy
// of the queue and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module deadline_ordered_tx_queue_chk
	import dotq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [135:0]         s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [127:0]         m_tdata,
	input  logic [2:0]           m_tuser,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]   kind;
		logic         last;
		logic [127:0] data;
	} txq_result_t;

	txq_result_t expected_results[$];

	logic [21:0] lim_bytes;
	logic [31:0] deadline;
	logic        dedup_on;
	logic [15:0] cur_rnti;
	logic [4:0]  cur_lcid;

	logic [15:0] q_handle[QUEUE_DEPTH];
	logic [15:0] q_bytes[QUEUE_DEPTH];
	logic [31:0] q_time[QUEUE_DEPTH];
	logic [11:0] q_seq[QUEUE_DEPTH];
	int          q_count;
	logic [21:0] q_total;

	assign pending = expected_results.size();

	function automatic logic [31:0] elapsed(logic [31:0] now, logic [31:0] ts);
		return (now >= ts) ? now - ts : 32'd0;
	endfunction

	function automatic void push_result(kind_t k, logic [15:0] h, logic [15:0] b,
		logic [11:0] s, logic [1:0] ly, logic [3:0] hq, logic [2:0] cc,
		logic [21:0] qb, logic [31:0] hol);
		txq_result_t r;
		r.kind = k;
		r.last = 1'b0;
		r.data = {cur_lcid, cur_rnti, hol, qb, cc, hq, ly, s, b, h};
		expected_results.push_back(r);
	endfunction

	function automatic void drop_entry(int i);
		q_total = q_total - 22'(q_bytes[i]);
		for (int j = i; j + 1 < q_count; j++) begin
			q_handle[j] = q_handle[j+1];
			q_bytes[j] = q_bytes[j+1];
			q_time[j] = q_time[j+1];
			q_seq[j] = q_seq[j+1];
		end
		q_count--;
	endfunction

	function automatic void run_report(logic [31:0] now);
		bit seen[DEDUP_SLOTS];
		int i;
		foreach (seen[k]) seen[k] = 0;
		if (deadline != 0) begin
			i = 0;
			while (i < q_count) begin
				if (elapsed(now, q_time[i]) > deadline) begin
					push_result(KIND_DEADLINE, q_handle[i], q_bytes[i], q_seq[i],
						'0, '0, '0, '0, '0);
					drop_entry(i);
				end else i++;
			end
		end
		if (dedup_on) begin
			i = 0;
			while (i < q_count) begin
				if (seen[q_seq[i] % DEDUP_SLOTS]) begin
					push_result(KIND_DUP, q_handle[i], q_bytes[i], q_seq[i],
						'0, '0, '0, '0, '0);
					drop_entry(i);
				end else begin
					seen[q_seq[i] % DEDUP_SLOTS] = 1;
					i++;
				end
			end
		end
		if (q_count > 0)
			push_result(KIND_STATUS, '0, '0, '0, '0, '0, '0, q_total,
				elapsed(now, q_time[0]));
		else
			push_result(KIND_STATUS, '0, '0, '0, '0, '0, '0, '0, '0);
	endfunction

	// Predicts the results of one accepted request and queues them.
	function automatic void predict_request(logic [1:0] req, logic [135:0] d);
		logic [31:0] now, ts;
		logic [15:0] h, b, g;
		logic [11:0] s;
		int before_n, pos;
		now = d[31:0];
		h = d[47:32];
		b = d[63:48];
		ts = d[95:64];
		s = d[107:96];
		g = d[123:108];
		before_n = expected_results.size();
		if (req == REQ_ENQUEUE) begin
			if (23'(q_total) + 23'(b) > 23'(lim_bytes) || q_count >= QUEUE_DEPTH) begin
				push_result(KIND_REJECT, h, b, s, '0, '0, '0, '0, '0);
			end else begin
				pos = q_count;
				if (deadline != 0) begin
					pos = 0;
					for (int i = 0; i < q_count; i++)
						if (q_time[i] <= ts) pos++;
				end
				for (int i = q_count; i > pos; i--) begin
					q_handle[i] = q_handle[i-1];
					q_bytes[i] = q_bytes[i-1];
					q_time[i] = q_time[i-1];
					q_seq[i] = q_seq[i-1];
				end
				q_handle[pos] = h;
				q_bytes[pos] = b;
				q_time[pos] = ts;
				q_seq[pos] = s;
				q_count++;
				q_total = q_total + 22'(b);
			end
			run_report(now);
		end else if (req == REQ_GRANT) begin
			if (q_count > 0 && g >= q_bytes[0]) begin
				push_result(KIND_SENT, q_handle[0], q_bytes[0], q_seq[0],
					d[125:124], d[129:126], d[132:130], '0, '0);
				drop_entry(0);
			end
		end else if (req == REQ_TICK) begin
			if (q_count > 0) run_report(now);
		end
		if (expected_results.size() > before_n)
			expected_results[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		txq_result_t want;
		if (!arst_n) begin
			lim_bytes <= MAX_BYTES_RST;
			deadline <= '0;
			dedup_on <= 1'b0;
			cur_rnti <= '0;
			cur_lcid <= '0;
			q_count = 0;
			q_total = '0;
			errors <= 0;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result kind %0d data %h", $time, m_tuser,
						m_tdata);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.kind !== m_tuser || want.last !== m_tlast
						|| want.data !== m_tdata) begin
						$display("%0t: mismatch expected kind %0d last %0d data %h",
							$time, want.kind, want.last, want.data);
						$display("%0t:          actual kind %0d last %0d data %h",
							$time, m_tuser, m_tlast, m_tdata);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_BYTES: lim_bytes <= cfg_data[21:0];
					CFG_DISCARD: deadline <= cfg_data;
					CFG_DEDUP: dedup_on <= cfg_data[0];
					CFG_RNTI: cur_rnti <= cfg_data[15:0];
					CFG_LCID: cur_lcid <= cfg_data[4:0];
					default: ;
				endcase
			end
		end
	end

endmodule

/* tb/sv/deadline_ordered_tx_queue_tb.sv */
// ----------------------------------------------------------------------------
// deadline_ordered_tx_queue_tb
// Drives enqueues, grants and report ticks into the transmit queue through
// several register settings and idle patterns; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module deadline_ordered_tx_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dotq_pkg::*;

	localparam longint CYCLE_LIMIT = 3_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [135:0]         s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [127:0]         m_tdata;
	logic [2:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	int                   errors;
	int                   pending;

	// Idle pattern in percent for each side, and a long sink hold-off.
	int      send_idle_pct = 0;
	int      sink_stall_pct = 0;
	int      hold_cycles = 0;
	longint  cycles = 0;

	// Time base of the stimulus; timestamps cluster around it.
	logic [31:0] clock_ms = 32'd1000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	deadline_ordered_tx_queue dut (.*);

	deadline_ordered_tx_queue_chk checker_i (.*);

	// The sink stalls at random, or fully while a hold-off is counting down.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one request and holds it until the block takes it. The block is
	// busy in the cycle after it takes a request, so dropping valid for that
	// cycle costs no throughput.
	task automatic send_request(req_t req, logic [31:0] now, logic [15:0] handle,
		logic [15:0] bytes, logic [31:0] ts, logic [11:0] seq, logic [15:0] grant,
		logic [1:0] layer, logic [3:0] harq, logic [2:0] carrier);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b0, carrier, harq, layer, grant, seq, ts, bytes, handle, now};
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic enqueue(logic [31:0] now, logic [15:0] handle, logic [15:0] bytes,
		logic [31:0] ts, logic [11:0] seq);
		send_request(REQ_ENQUEUE, now, handle, bytes, ts, seq, 16'($urandom),
			2'($urandom), 4'($urandom), 3'($urandom));
	endtask

	task automatic grant(logic [31:0] now, logic [15:0] g);
		send_request(REQ_GRANT, now, 16'($urandom), 16'($urandom), $urandom,
			12'($urandom), g, 2'($urandom), 4'($urandom), 3'($urandom));
	endtask

	task automatic tick(logic [31:0] now);
		send_request(REQ_TICK, now, 16'($urandom), 16'($urandom), $urandom,
			12'($urandom), 16'($urandom), 2'($urandom), 4'($urandom), 3'($urandom));
	endtask

	// Waits for every expected result, then for the worst scan to finish.
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [21:0] lim, logic [31:0] dl, logic dd);
		drain();
		write_reg(CFG_MAX_BYTES, 32'(lim));
		write_reg(CFG_DISCARD, dl);
		write_reg(CFG_DEDUP, 32'(dd));
		write_reg(CFG_RNTI, $urandom);
		write_reg(CFG_LCID, $urandom);
	endtask

	// Random traffic: mostly enqueues with timestamps near the time base so that
	// ordering, deadline drops and duplicates all happen; small sizes mostly.
	task automatic random_traffic(int n, int grant_pct);
		int r;
		logic [15:0] sz;
		for (int i = 0; i < n; i++) begin
			clock_ms = clock_ms + $urandom_range(40);
			r = $urandom_range(99);
			if (r < 5) begin
				// Unknown request type: the block ignores it.
				send_request(req_t'(2'd3), $urandom, 16'($urandom), 16'($urandom),
					$urandom, 12'($urandom), 16'($urandom), 2'($urandom),
					4'($urandom), 3'($urandom));
				i--;
			end else if (r < 5 + grant_pct) begin
				grant(clock_ms, ($urandom_range(9) == 0) ? 16'($urandom)
					: 16'($urandom_range(3000)));
			end else if (r < 15 + grant_pct) begin
				tick(clock_ms);
			end else begin
				sz = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
				enqueue(($urandom_range(49) == 0) ? $urandom : clock_ms, 16'($urandom), sz,
					($urandom_range(49) == 0) ? $urandom
						: clock_ms - $urandom_range(150) + 20,
					($urandom_range(3) == 0) ? 12'($urandom_range(4)) : 12'($urandom));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings: appending, grants that fit exactly and
		// with room, a tick and grants on an empty queue, field extremes.
		tick(32'hFFFF_FFFF);
		grant(32'd0, 16'hFFFF);
		enqueue(32'd0, 16'h0000, 16'h0000, 32'h0000_0000, 12'h000);
		enqueue(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF);
		enqueue(32'd5, 16'h1234, 16'd10, 32'd100, 12'd7);
		grant(32'd5, 16'd0);
		send_request(REQ_GRANT, 32'd0, 16'd0, 16'd0, 32'd0, 12'd0, 16'hFFFF, 2'd3,
			4'd15, 3'd7);
		grant(32'd5, 16'hFFFE);
		tick(32'd200);
		grant(32'd0, 16'hFFFF);
		grant(32'd0, 16'hFFFF);

		// Deadline ordering and purge, duplicates, rejection by byte limit.
		set_config(22'd1000, 32'd50, 1'b1);
		enqueue(32'd100, 16'd1, 16'd100, 32'd90, 12'd5);
		enqueue(32'd100, 16'd2, 16'd100, 32'd80, 12'd105);
		enqueue(32'd100, 16'd3, 16'd100, 32'd95, 12'd205);
		enqueue(32'd100, 16'd4, 16'd900, 32'd95, 12'd9);
		enqueue(32'd50, 16'd5, 16'd100, 32'd200, 12'd6);
		tick(32'd300);
		tick(32'd300);

		// Store full: limit at maximum, no deadline, 34 enqueues.
		set_config(22'h3F_FFFF, 32'd0, 1'b0);
		for (int i = 0; i < QUEUE_DEPTH + 2; i++)
			enqueue(32'd10, 16'(i), 16'd1, 32'(i), 12'(i));
		for (int i = 0; i < QUEUE_DEPTH; i++) grant(32'd10, 16'hFFFF);

		// Deadline at its maximum with dedup off, limit zero.
		set_config(22'd0, 32'hFFFF_FFFF, 1'b0);
		enqueue(32'd7, 16'd9, 16'd0, 32'd3, 12'd1);
		enqueue(32'd7, 16'd8, 16'd1, 32'd3, 12'd1);
		grant(32'd7, 16'd0);

		// Random phases with varied settings and idle patterns.
		for (int phase = 0; phase < 8; phase++) begin
			set_config((phase % 4 == 0) ? 22'h3F_FFFF : 22'($urandom_range(60000) + 2000),
				(phase % 3 == 0) ? 32'd0 : 32'($urandom_range(200) + 1), phase[0]);
			case (phase % 4)
				0: begin send_idle_pct = 0; sink_stall_pct = 0; end
				1: begin send_idle_pct = 77; sink_stall_pct = 0; end
				2: begin send_idle_pct = 0; sink_stall_pct = 77; end
				default: begin send_idle_pct = 33; sink_stall_pct = 33; end
			endcase
			if (phase == 4) hold_cycles = 3000;
			random_traffic(46, (phase == 4) ? 5 : 25);
			if (phase == 2) begin
				// Pause the sender until everything has come out.
				while (pending != 0) @(posedge clk);
			end
		end

		drain();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/dotq_pkg.sv
rtl/dotq_ctrl.sv
rtl/dotq_dp.sv
rtl/deadline_ordered_tx_queue.sv
tb/sv/deadline_ordered_tx_queue_chk.sv
tb/sv/deadline_ordered_tx_queue_tb.sv
